FILE: sv/ps2hp_pkg.sv
// Shared types and constants for the PS/2 host port.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package ps2hp_pkg;

  localparam logic [1:0] KIND_TICK = 2'd0;
  localparam logic [1:0] KIND_SEND = 2'd1;
  localparam logic [1:0] KIND_RECV = 2'd2;

  localparam logic [1:0] CFG_TIMEOUT  = 2'd0;
  localparam logic [1:0] CFG_INHIBIT  = 2'd1;
  localparam logic [1:0] CFG_POST     = 2'd2;
  localparam logic [1:0] CFG_HOLD_CLK = 2'd3;

  localparam logic [23:0] TIMEOUT_RESET  = 24'd50000;
  localparam logic [15:0] INHIBIT_RESET  = 16'd100;
  localparam logic [15:0] POST_RESET     = 16'd50;
  localparam logic        HOLD_CLK_RESET = 1'b1;

  localparam logic [7:0] ACK_CODE = 8'hFA;

  typedef struct packed {
    logic [7:0] send_byte;
    logic       data_line;
    logic       clock_line;
    logic [1:0] kind;
  } ps2hp_item_t;

  typedef struct packed {
    logic [23:0] timeout_ticks;
    logic [15:0] inhibit_ticks;
    logic [15:0] post_receive_ticks;
    logic        hold_clock_after_receive;
  } ps2hp_cfg_t;

  typedef struct packed {
    logic       busy_res;
    logic       timeout_flag;
    logic       ack_error;
    logic       line_control_error;
    logic       framing_error;
    logic       parity_error;
    logic [7:0] received_byte;
    logic       byte_valid;
    logic       data_pull_low;
    logic       clock_pull_low;
  } ps2hp_result_t;

endpackage

FILE: sv/ps2hp_cfg_regs.sv
// Configuration register bank of the PS/2 host port.
// Depends on ps2hp_pkg for register indexes, reset values and the config struct.
`timescale 1ns / 1ps

module ps2hp_cfg_regs (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [1:0]           wr_index,
  input  logic [23:0]          wr_data,
  output ps2hp_pkg::ps2hp_cfg_t cfg
);
  import ps2hp_pkg::*;

  ps2hp_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.timeout_ticks            <= TIMEOUT_RESET;
      cfg_r.inhibit_ticks            <= INHIBIT_RESET;
      cfg_r.post_receive_ticks       <= POST_RESET;
      cfg_r.hold_clock_after_receive <= HOLD_CLK_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        CFG_TIMEOUT:  cfg_r.timeout_ticks            <= wr_data;
        CFG_INHIBIT:  cfg_r.inhibit_ticks            <= wr_data[15:0];
        CFG_POST:     cfg_r.post_receive_ticks       <= wr_data[15:0];
        CFG_HOLD_CLK: cfg_r.hold_clock_after_receive <= wr_data[0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: sv/ps2hp_core.sv
// Protocol state machine of the PS/2 host port: one update per accepted item.
// Depends on ps2hp_pkg for the item, config and result structs.
`timescale 1ns / 1ps

module ps2hp_core #(
  parameter int TIMER_BITS = 24
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    adv,
  input  ps2hp_pkg::ps2hp_item_t   item,
  input  ps2hp_pkg::ps2hp_cfg_t    cfg,
  output ps2hp_pkg::ps2hp_result_t res
);
  import ps2hp_pkg::*;

  localparam int CW = (TIMER_BITS > 24) ? TIMER_BITS : 24;
  localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};

  // Wait phases awaiting a low clock have even codes, those awaiting high odd.
  typedef enum logic [4:0] {
    P_IDLE       = 5'd0,
    P_S_INH      = 5'd1,
    P_S_BIT_LO   = 5'd2,
    P_S_BIT_HI   = 5'd3,
    P_S_PAR_LO   = 5'd4,
    P_S_PAR_HI   = 5'd5,
    P_S_STOP_LO  = 5'd6,
    P_S_STOP_HI  = 5'd7,
    P_S_LC_LO    = 5'd8,
    P_S_LC_HI    = 5'd9,
    P_R_START_LO = 5'd10,
    P_R_START_HI = 5'd11,
    P_R_BIT_LO   = 5'd12,
    P_R_BIT_HI   = 5'd13,
    P_R_PAR_LO   = 5'd14,
    P_R_PAR_HI   = 5'd15,
    P_R_STOP_LO  = 5'd16,
    P_R_POST     = 5'd17
  } phase_t;

  phase_t                phase_r, phase_nxt;
  logic [3:0]            bit_count_r, bit_count_nxt;
  logic [7:0]            shift_reg_r, shift_reg_nxt;
  logic                  parity_acc_r, parity_acc_nxt;
  logic [TIMER_BITS-1:0] wait_timer_r, wait_timer_nxt;
  logic                  reply_expected_r, reply_expected_nxt;
  logic                  clock_held_r, clock_held_nxt;
  logic                  data_low_r, data_low_nxt;
  logic [7:0]            last_byte_r, last_byte_nxt;
  logic                  f_par_r, f_par_nxt;
  logic                  f_frm_r, f_frm_nxt;
  logic                  f_lc_r, f_lc_nxt;
  logic                  f_ack_r, f_ack_nxt;
  logic                  f_to_r, f_to_nxt;

  logic [TIMER_BITS-1:0] tinc;
  logic                  valid;
  logic                  go;
  logic                  start_rx;
  logic                  start_rx_reply;
  logic [3:0]            bc_inc;

  assign tinc   = (wait_timer_r == TMAX) ? wait_timer_r : wait_timer_r + TIMER_BITS'(1);
  assign bc_inc = bit_count_r + 4'd1;

  always_comb begin
    phase_nxt          = phase_r;
    bit_count_nxt      = bit_count_r;
    shift_reg_nxt      = shift_reg_r;
    parity_acc_nxt     = parity_acc_r;
    wait_timer_nxt     = wait_timer_r;
    reply_expected_nxt = reply_expected_r;
    clock_held_nxt     = clock_held_r;
    data_low_nxt       = data_low_r;
    last_byte_nxt      = last_byte_r;
    f_par_nxt          = f_par_r;
    f_frm_nxt          = f_frm_r;
    f_lc_nxt           = f_lc_r;
    f_ack_nxt          = f_ack_r;
    f_to_nxt           = f_to_r;
    valid              = 1'b0;
    go                 = 1'b0;
    start_rx           = 1'b0;
    start_rx_reply     = 1'b0;

    if (item.kind == KIND_SEND || item.kind == KIND_RECV) begin
      if (phase_r == P_IDLE) begin
        f_par_nxt = 1'b0;
        f_frm_nxt = 1'b0;
        f_lc_nxt  = 1'b0;
        f_ack_nxt = 1'b0;
        f_to_nxt  = 1'b0;
        if (item.kind == KIND_SEND) begin
          clock_held_nxt     = 1'b1;
          data_low_nxt       = 1'b0;
          shift_reg_nxt      = item.send_byte;
          bit_count_nxt      = 4'd0;
          parity_acc_nxt     = 1'b1;
          wait_timer_nxt     = '0;
          reply_expected_nxt = 1'b0;
          phase_nxt          = P_S_INH;
        end else begin
          start_rx = 1'b1;
        end
      end
    end else begin
      unique case (phase_r)
        P_IDLE: ;
        P_S_INH: begin
          wait_timer_nxt = tinc;
          if (CW'(tinc) >= CW'(cfg.inhibit_ticks)) begin
            data_low_nxt   = 1'b1;
            clock_held_nxt = 1'b0;
            wait_timer_nxt = '0;
            phase_nxt      = P_S_BIT_LO;
          end
        end
        P_R_POST: begin
          wait_timer_nxt = tinc;
          if (CW'(tinc) >= CW'(cfg.post_receive_ticks)) begin
            valid         = 1'b1;
            last_byte_nxt = shift_reg_r;
            if (cfg.hold_clock_after_receive) begin
              clock_held_nxt = 1'b1;
            end
            if (reply_expected_r && shift_reg_r != ACK_CODE) begin
              f_ack_nxt = 1'b1;
            end
            reply_expected_nxt = 1'b0;
            wait_timer_nxt     = '0;
            phase_nxt          = P_IDLE;
          end
        end
        default: begin
          if (item.clock_line != phase_r[0]) begin
            wait_timer_nxt = tinc;
            if (CW'(tinc) >= CW'(cfg.timeout_ticks)) begin
              f_to_nxt = 1'b1;
              go       = 1'b1;
            end
          end else begin
            go = 1'b1;
          end
        end
      endcase

      if (go) begin
        wait_timer_nxt = '0;
        unique case (phase_r)
          P_S_BIT_LO: begin
            data_low_nxt   = ~shift_reg_r[0];
            parity_acc_nxt = parity_acc_r ^ shift_reg_r[0];
            phase_nxt      = P_S_BIT_HI;
          end
          P_S_BIT_HI: begin
            shift_reg_nxt = shift_reg_r >> 1;
            bit_count_nxt = bc_inc;
            phase_nxt     = (bc_inc >= 4'd8) ? P_S_PAR_LO : P_S_BIT_LO;
          end
          P_S_PAR_LO: begin
            data_low_nxt = ~parity_acc_r;
            phase_nxt    = P_S_PAR_HI;
          end
          P_S_PAR_HI:  phase_nxt = P_S_STOP_LO;
          P_S_STOP_LO: begin
            data_low_nxt = 1'b0;
            phase_nxt    = P_S_STOP_HI;
          end
          P_S_STOP_HI: phase_nxt = P_S_LC_LO;
          P_S_LC_LO: begin
            if (item.data_line) begin
              f_lc_nxt = 1'b1;
            end
            phase_nxt = P_S_LC_HI;
          end
          P_S_LC_HI: begin
            start_rx       = 1'b1;
            start_rx_reply = 1'b1;
          end
          P_R_START_LO: phase_nxt = P_R_START_HI;
          P_R_START_HI: phase_nxt = P_R_BIT_LO;
          P_R_BIT_LO: begin
            shift_reg_nxt  = {item.data_line, shift_reg_r[7:1]};
            parity_acc_nxt = parity_acc_r ^ item.data_line;
            phase_nxt      = P_R_BIT_HI;
          end
          P_R_BIT_HI: begin
            bit_count_nxt = bc_inc;
            phase_nxt     = (bc_inc >= 4'd8) ? P_R_PAR_LO : P_R_BIT_LO;
          end
          P_R_PAR_LO: begin
            parity_acc_nxt = parity_acc_r ^ item.data_line;
            if (!(parity_acc_r ^ item.data_line)) begin
              f_par_nxt = 1'b1;
            end
            phase_nxt = P_R_PAR_HI;
          end
          P_R_PAR_HI:  phase_nxt = P_R_STOP_LO;
          P_R_STOP_LO: begin
            if (!item.data_line) begin
              f_frm_nxt = 1'b1;
            end
            phase_nxt = P_R_POST;
          end
          default: ;
        endcase
      end
    end

    if (start_rx) begin
      clock_held_nxt     = 1'b0;
      data_low_nxt       = 1'b0;
      bit_count_nxt      = 4'd0;
      shift_reg_nxt      = 8'd0;
      parity_acc_nxt     = 1'b0;
      wait_timer_nxt     = '0;
      reply_expected_nxt = start_rx_reply;
      phase_nxt          = P_R_START_LO;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r          <= P_IDLE;
      bit_count_r      <= 4'd0;
      shift_reg_r      <= 8'd0;
      parity_acc_r     <= 1'b0;
      wait_timer_r     <= '0;
      reply_expected_r <= 1'b0;
      clock_held_r     <= 1'b0;
      data_low_r       <= 1'b0;
      last_byte_r      <= 8'd0;
      f_par_r          <= 1'b0;
      f_frm_r          <= 1'b0;
      f_lc_r           <= 1'b0;
      f_ack_r          <= 1'b0;
      f_to_r           <= 1'b0;
    end else if (adv) begin
      phase_r          <= phase_nxt;
      bit_count_r      <= bit_count_nxt;
      shift_reg_r      <= shift_reg_nxt;
      parity_acc_r     <= parity_acc_nxt;
      wait_timer_r     <= wait_timer_nxt;
      reply_expected_r <= reply_expected_nxt;
      clock_held_r     <= clock_held_nxt;
      data_low_r       <= data_low_nxt;
      last_byte_r      <= last_byte_nxt;
      f_par_r          <= f_par_nxt;
      f_frm_r          <= f_frm_nxt;
      f_lc_r           <= f_lc_nxt;
      f_ack_r          <= f_ack_nxt;
      f_to_r           <= f_to_nxt;
    end
  end

  always_comb begin
    res.clock_pull_low     = clock_held_nxt;
    res.data_pull_low      = data_low_nxt;
    res.byte_valid         = valid;
    res.received_byte      = last_byte_nxt;
    res.parity_error       = f_par_nxt;
    res.framing_error      = f_frm_nxt;
    res.line_control_error = f_lc_nxt;
    res.ack_error          = f_ack_nxt;
    res.timeout_flag       = f_to_nxt;
    res.busy_res           = (phase_nxt != P_IDLE);
  end

endmodule

FILE: sv/ps2hp_out_stage.sv
// Result register of the PS/2 host port, parting the core from the output stream.
// Depends on ps2hp_pkg for the result struct.
`timescale 1ns / 1ps

module ps2hp_out_stage (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    load,
  input  logic                    take,
  input  ps2hp_pkg::ps2hp_result_t res_in,
  output logic                    valid,
  output ps2hp_pkg::ps2hp_result_t res_out
);
  import ps2hp_pkg::*;

  logic          valid_r, valid_nxt;
  ps2hp_result_t res_r;

  assign valid_nxt = load | (valid_r & ~take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  assign valid   = valid_r;
  assign res_out = res_r;

endmodule

FILE: sv/ps2_host_port.sv
// Top level of the PS/2 host port: stream ports, input register, config registers, core and result stage.
// Depends on ps2hp_pkg, ps2hp_cfg_regs, ps2hp_core and ps2hp_out_stage.
//
//   port group   direction   carries
//   in_          slave       tick samples and send/receive commands
//   out_         master      line drives, received byte, status flags
//   cfg_         slave       register writes, index and data
//
// One item is taken every cycle while the output is not stalled; each result passes
// through the input register and then the result register.
// Reset (rst_n, synchronous, low) idles the state machine and loads register defaults.
// A stalled output holds its result; the input register still takes one more item,
// and further items wait until the result is taken.
`timescale 1ns / 1ps

module ps2_host_port #(
  parameter int TIMER_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // clock_line, data_line, send_byte[7:0], zero fill
  input  logic [1:0]  in_tuser,   // kind[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // clock_pull_low, data_pull_low, byte_valid,
                                  // received_byte[7:0], parity_error, framing_error,
                                  // line_control_error, ack_error, timeout_flag,
                                  // busy_res, zero fill
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);
  import ps2hp_pkg::*;

  logic          in_valid_r;
  ps2hp_item_t   item_r;
  logic          adv;
  ps2hp_cfg_t    cfg;
  ps2hp_result_t core_res;
  ps2hp_result_t out_res;

  assign cfg_ready = 1'b1;
  assign adv       = in_valid_r & (~out_tvalid | out_tready);
  assign in_tready = ~in_valid_r | adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r.kind       <= in_tuser;
      item_r.clock_line <= in_tdata[0];
      item_r.data_line  <= in_tdata[1];
      item_r.send_byte  <= in_tdata[9:2];
    end
  end

  ps2hp_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  ps2hp_core #(
    .TIMER_BITS (TIMER_BITS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .item  (item_r),
    .cfg   (cfg),
    .res   (core_res)
  );

  ps2hp_out_stage u_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (adv),
    .take    (out_tready),
    .res_in  (core_res),
    .valid   (out_tvalid),
    .res_out (out_res)
  );

  assign out_tdata = {7'd0, out_res};

  a_byte_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[2] && out_tdata[16]))
    else $error("byte_valid reported while still busy");

  a_adv_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_tvalid)
    else $error("processed item produced no result");

  a_item_held: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !adv) |=> (in_valid_r && $stable(item_r)))
    else $error("pending item lost before processing");

endmodule
